[rtl/brr_pkg.sv]
// Shared types and constants for the BRR block decoder.
// No dependencies; every other file imports this package.
package brr_pkg;

    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 24;

    // block position codes
    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_FIRST  = 4'd1;
    localparam logic [3:0] POS_LAST   = 4'd8;

    localparam logic [3:0] SHIFT_MAX = 4'd12;

    // predictor filter codes
    localparam logic [1:0] FILT_NONE = 2'd0;
    localparam logic [1:0] FILT_ONE  = 2'd1;
    localparam logic [1:0] FILT_TWO  = 2'd2;
    localparam logic [1:0] FILT_THREE = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] pcm_word_t;

    // contents of the input holding register
    typedef struct packed {
        logic              valid;
        logic              start;
        logic [BYTE_W-1:0] data;
    } in_slot_t;

endpackage

[rtl/brr_stream_if.sv]
// Byte channel into the BRR decoder: valid/ready plus the stream byte fields.
// Depends on brr_pkg.
interface brr_stream_if
    import brr_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    logic              stream_start;

    modport source (output valid, output stream_byte, output stream_start, input ready);
    modport sink   (input valid, input stream_byte, input stream_start, output ready);
endinterface

[rtl/brr_sample_if.sv]
// Sample channel out of the BRR decoder: valid/ready plus the sample fields.
// Depends on brr_pkg.
interface brr_sample_if
    import brr_pkg::*;
    ();
    logic      valid;
    logic      ready;
    pcm_word_t pcm_sample;
    logic      pair_last;
    logic      block_loop;
    logic      block_end;

    modport source (output valid, output pcm_sample, output pair_last,
                    output block_loop, output block_end, input ready);
    modport sink   (input valid, input pcm_sample, input pair_last,
                    input block_loop, input block_end, output ready);
endinterface

[rtl/brr_in_stage.sv]
// Input holding register of the BRR decoder.
// Depends on brr_pkg and brr_stream_if.
module brr_in_stage
    import brr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    brr_stream_if.sink        stream,
    input  logic              consume,
    output in_slot_t          slot
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              start_reg;
    logic              accept;

    // take a new item when empty or when the held one leaves this cycle
    assign stream.ready = !valid_reg || consume;
    assign accept       = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg  <= stream.stream_byte;
            start_reg <= stream.stream_start;
        end
    end

    assign slot.valid = valid_reg;
    assign slot.start = start_reg;
    assign slot.data  = data_reg;

endmodule

[rtl/brr_sample_calc.sv]
// One BRR sample: sign-extend and shift a nibble, add the fixed-coefficient
// prediction from the last two samples, wrap to 16 bits. Depends on brr_pkg.
module brr_sample_calc
    import brr_pkg::*;
(
    input  logic [3:0] nibble,
    input  logic [3:0] shift,
    input  logic [1:0] filter,
    input  pcm_word_t  prior,
    input  pcm_word_t  older,
    output pcm_word_t  sample
);

    logic signed [PROD_W-1:0] p_ext;
    logic signed [PROD_W-1:0] q_ext;
    logic signed [PROD_W-1:0] p15;
    logic signed [PROD_W-1:0] p61;
    logic signed [PROD_W-1:0] p115;
    logic signed [PROD_W-1:0] q15;
    logic signed [PROD_W-1:0] q13;
    logic signed [PROD_W-1:0] p15_s;
    logic signed [PROD_W-1:0] p61_s;
    logic signed [PROD_W-1:0] p115_s;
    logic signed [PROD_W-1:0] q15_s;
    logic signed [PROD_W-1:0] q13_s;
    pcm_word_t                nib_ext;
    pcm_word_t                scaled;
    pcm_word_t                pred;

    assign nib_ext = pcm_word_t'({{(SAMPLE_W-4){nibble[3]}}, nibble});
    assign scaled  = nib_ext <<< shift;

    assign p_ext = PROD_W'(prior);
    assign q_ext = PROD_W'(older);

    // constant multiplies as shift-and-add
    assign p15  = (p_ext <<< 4) - p_ext;
    assign p61  = (p_ext <<< 6) - (p_ext <<< 1) - p_ext;
    assign p115 = (p_ext <<< 7) - (p_ext <<< 3) - (p_ext <<< 2) - p_ext;
    assign q15  = (q_ext <<< 4) - q_ext;
    assign q13  = (q_ext <<< 3) + (q_ext <<< 2) + q_ext;

    // arithmetic right shift floors
    assign p15_s  = p15  >>> 4;
    assign p61_s  = p61  >>> 5;
    assign p115_s = p115 >>> 6;
    assign q15_s  = q15  >>> 4;
    assign q13_s  = q13  >>> 4;

    always_comb
    begin
        case (filter)
            FILT_NONE:  pred = '0;
            FILT_ONE:   pred = pcm_word_t'(p15_s[SAMPLE_W-1:0]);
            FILT_TWO:   pred = pcm_word_t'(p61_s[SAMPLE_W-1:0] - q15_s[SAMPLE_W-1:0]);
            FILT_THREE: pred = pcm_word_t'(p115_s[SAMPLE_W-1:0] - q13_s[SAMPLE_W-1:0]);
            default:    pred = '0;
        endcase
    end

    assign sample = scaled + pred;

endmodule

[rtl/brr_adpcm_block_decoder.sv]
// Top level of the BRR block decoder: header tracking, sample history,
// nibble sequencing and the output register. Depends on brr_pkg, both
// channel interfaces, brr_in_stage and brr_sample_calc.
//
// The decoder takes one stream byte per item. A header byte is absorbed and
// yields no sample; a data byte is held in the input register while it yields
// two samples, high nibble first, one per cycle while the output accepts them,
// because the predictor output of each sample is the history for the next. A
// sample appears at the output in the cycle after its nibble is worked; the
// input register accepts the next byte in the same cycle that the low nibble
// of the current byte is worked. A header byte is absorbed even while a sample
// waits downstream, but a nibble is worked only when the output register is
// empty or is read in that cycle.
module brr_adpcm_block_decoder
    import brr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    brr_stream_if.sink   stream,
    brr_sample_if.source sample
);

    in_slot_t   slot;
    logic       consume;

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [3:0] shift_reg;
    logic [3:0] shift_next;
    logic [1:0] filter_reg;
    logic [1:0] filter_next;
    logic       loop_reg;
    logic       loop_next;
    logic       end_reg;
    logic       end_next;
    pcm_word_t  prior_reg;
    pcm_word_t  prior_next;
    pcm_word_t  older_reg;
    pcm_word_t  older_next;
    logic       phase_reg;
    logic       phase_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    pcm_word_t  out_sample_reg;
    logic       out_last_reg;
    logic       out_loop_reg;
    logic       out_end_reg;

    logic       start_eff;
    logic [3:0] pos_eff;
    pcm_word_t  prior_eff;
    pcm_word_t  older_eff;
    logic       is_header;
    logic       out_free;
    logic       step;
    logic       data_step;
    logic [3:0] nibble;
    logic [3:0] hdr_shift;
    pcm_word_t  new_sample;

    brr_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream),
        .consume (consume),
        .slot    (slot)
    );

    // a start flag acts only when the byte is first worked
    assign start_eff = slot.start && !phase_reg;
    assign pos_eff   = start_eff ? POS_HEADER : pos_reg;
    assign prior_eff = start_eff ? pcm_word_t'(0) : prior_reg;
    assign older_eff = start_eff ? pcm_word_t'(0) : older_reg;
    assign is_header = (pos_eff == POS_HEADER) || (pos_eff > POS_LAST);

    assign out_free  = !out_valid_reg || sample.ready;
    assign step      = slot.valid && (is_header || out_free);
    assign data_step = step && !is_header;
    assign consume   = step && (is_header || phase_reg);

    assign nibble    = phase_reg ? slot.data[3:0] : slot.data[7:4];
    assign hdr_shift = (slot.data[7:4] > SHIFT_MAX) ? SHIFT_MAX : slot.data[7:4];

    brr_sample_calc u_sample_calc (
        .nibble (nibble),
        .shift  (shift_reg),
        .filter (filter_reg),
        .prior  (prior_eff),
        .older  (older_eff),
        .sample (new_sample)
    );

    always_comb
    begin
        pos_next       = pos_reg;
        shift_next     = shift_reg;
        filter_next    = filter_reg;
        loop_next      = loop_reg;
        end_next       = end_reg;
        prior_next     = prior_reg;
        older_next     = older_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !sample.ready;

        if (step && is_header)
        begin
            shift_next  = hdr_shift;
            filter_next = slot.data[3:2];
            loop_next   = slot.data[1];
            end_next    = slot.data[0];
            pos_next    = POS_FIRST;
            prior_next  = prior_eff;
            older_next  = older_eff;
        end
        else if (data_step)
        begin
            prior_next     = new_sample;
            older_next     = prior_eff;
            phase_next     = !phase_reg;
            out_valid_next = 1'b1;
            if (phase_reg)
            begin
                // advance the block position after the low nibble
                pos_next = (pos_eff >= POS_LAST) ? POS_HEADER : pos_eff + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_HEADER;
            shift_reg     <= '0;
            filter_reg    <= FILT_NONE;
            loop_reg      <= 1'b0;
            end_reg       <= 1'b0;
            prior_reg     <= '0;
            older_reg     <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            shift_reg     <= shift_next;
            filter_reg    <= filter_next;
            loop_reg      <= loop_next;
            end_reg       <= end_next;
            prior_reg     <= prior_next;
            older_reg     <= older_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_step)
        begin
            out_sample_reg <= new_sample;
            out_last_reg   <= phase_reg;
            out_loop_reg   <= loop_reg;
            out_end_reg    <= end_reg;
        end
    end

    assign sample.valid      = out_valid_reg;
    assign sample.pcm_sample = out_sample_reg;
    assign sample.pair_last  = out_last_reg;
    assign sample.block_loop = out_loop_reg;
    assign sample.block_end  = out_end_reg;

`ifndef SYNTHESIS
    a_phase_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> slot.valid)
        else $error("low-nibble phase without a held item");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("block position out of range");

    a_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (data_step && phase_reg) |=> (sample.valid && sample.pair_last))
        else $error("low-nibble sample not presented");

    a_header_no_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_header) |=> !phase_reg)
        else $error("header byte left a nibble phase set");

    a_high_then_low: assert property (@(posedge clk) disable iff (!rst_n)
        (data_step && !phase_reg) |=> (phase_reg && sample.valid && !sample.pair_last))
        else $error("high-nibble sample did not set up the low nibble");
`endif

endmodule

[dv/brr_decode_checker.sv]
`timescale 1ns / 100ps
// Sample checker for the BRR block decoder: tracks header state and sample history,
// predicts the samples of every accepted byte and compares them in order.
// Depends on brr_pkg, brr_stream_if and brr_sample_if.
module brr_decode_checker
    import brr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    brr_stream_if stream,
    brr_sample_if sample,
    output int    error_count,
    output int    outstanding
);

    typedef struct packed {
        pcm_word_t pcm;
        logic      second;
        logic      loop_flag;
        logic      end_flag;
    } pcm_expect_t;

    pcm_expect_t pending_samples[$];

    logic [3:0] position  = POS_HEADER;
    logic [3:0] shift     = '0;
    logic [1:0] filter    = FILT_NONE;
    logic       loop_flag = 1'b0;
    logic       end_flag  = 1'b0;
    pcm_word_t  prior     = '0;
    pcm_word_t  older     = '0;
    int         errors    = 0;

    assign error_count = errors;

    // One filtered sample; advances the two-sample history.
    function automatic pcm_word_t next_sample(input logic [3:0] nib);
        int        scaled;
        int        prediction;
        int        p;
        int        q;
        pcm_word_t result;
        scaled = int'($signed(nib)) <<< shift;
        p = int'(prior);
        q = int'(older);
        // arithmetic right shifts give the floored terms
        case (filter)
            FILT_ONE:   prediction = (p * 15) >>> 4;
            FILT_TWO:   prediction = ((p * 61) >>> 5) - ((q * 15) >>> 4);
            FILT_THREE: prediction = ((p * 115) >>> 6) - ((q * 13) >>> 4);
            default:    prediction = 0;
        endcase
        result = pcm_word_t'(scaled + prediction);
        older = prior;
        prior = result;
        return result;
    endfunction

    function automatic void take_byte(input logic [7:0] b, input logic fresh);
        if (fresh)
        begin
            position = POS_HEADER;
            prior    = '0;
            older    = '0;
        end
        if (position == POS_HEADER || position > POS_LAST)
        begin
            shift     = (b[7:4] > SHIFT_MAX) ? SHIFT_MAX : b[7:4];
            filter    = b[3:2];
            loop_flag = b[1];
            end_flag  = b[0];
            position  = POS_FIRST;
        end
        else
        begin
            // high nibble first; the low nibble sees its result as history
            pending_samples.push_back('{next_sample(b[7:4]), 1'b0, loop_flag, end_flag});
            pending_samples.push_back('{next_sample(b[3:0]), 1'b1, loop_flag, end_flag});
            position = (position >= POS_LAST) ? POS_HEADER : position + 4'd1;
        end
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pcm_expect_t want;
        if (!rst_n)
        begin
            position  = POS_HEADER;
            shift     = '0;
            filter    = FILT_NONE;
            loop_flag = 1'b0;
            end_flag  = 1'b0;
            prior     = '0;
            older     = '0;
            pending_samples.delete();
            outstanding <= 0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                if (pending_samples.size() == 0)
                begin
                    errors++;
                    $display("%0t: pcm_sample expected none actual %0d", $time,
                             sample.pcm_sample);
                end
                else
                begin
                    want = pending_samples.pop_front();
                    check_field("pcm_sample", int'(want.pcm), int'(sample.pcm_sample));
                    check_field("pair_last", want.second, sample.pair_last);
                    check_field("block_loop", want.loop_flag, sample.block_loop);
                    check_field("block_end", want.end_flag, sample.block_end);
                end
            end
            if (stream.valid && stream.ready)
                take_byte(stream.stream_byte, stream.stream_start);
            outstanding <= pending_samples.size();
        end
    end

endmodule

[dv/brr_adpcm_block_decoder_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the BRR block decoder: clock, reset, byte stimulus, sample
// back-pressure and the verdict. Depends on brr_pkg, both channel interfaces,
// brr_adpcm_block_decoder and brr_decode_checker.
module brr_adpcm_block_decoder_tb
    import brr_pkg::*;
();

    localparam int ITEM_TARGET  = 650;
    localparam int SEGMENT      = 120;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    // {stream_start, stream_byte}: every filter, shift clamp, flags, boundaries
    localparam logic [8:0] OPENING [25] = '{
        9'h100, 9'h07F, 9'h080, 9'h0F0, 9'h00F,
        9'h1C4, 9'h07F, 9'h088, 9'h001,
        9'h1F8, 9'h077, 9'h088, 9'h077,
        9'h1DF, 9'h07F, 9'h080, 9'h008, 9'h077, 9'h088, 9'h0FF, 9'h000, 9'h012,
        9'h01E, 9'h0A5, 9'h05A
    };

    logic clk = 1'b0;
    logic rst_n;
    logic src_pauses;
    logic snk_pauses;
    int   bytes_sent;
    int   error_count;
    int   outstanding;

    brr_stream_if stream_ch ();
    brr_sample_if sample_ch ();

    brr_adpcm_block_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .sample (sample_ch)
    );

    brr_decode_checker sample_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream_ch),
        .sample      (sample_ch),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // Keep valid high across back-to-back items; drop it only for a gap.
    task automatic send_byte(input logic [7:0] b, input logic fresh);
        int gap;
        gap = src_pauses ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_ch.valid        <= 1'b1;
        stream_ch.stream_byte  <= b;
        stream_ch.stream_start <= fresh;
        @(posedge clk);
        while (!stream_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        stream_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Header plus eight data bytes; now and then cut short.
    task automatic send_block(input logic fresh, output logic broken);
        int data_bytes;
        send_byte(8'($urandom_range(0, 255)), fresh);
        broken = ($urandom_range(0, 15) == 0);
        data_bytes = broken ? $urandom_range(0, 7) : 8;
        repeat (data_bytes) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial
    begin : stimulus
        logic broken;
        logic fresh;
        int   segment_end;
        rst_n                  <= 1'b0;
        stream_ch.valid        <= 1'b0;
        stream_ch.stream_byte  <= '0;
        stream_ch.stream_start <= 1'b0;
        src_pauses = 1'b1;
        snk_pauses = 1'b1;
        bytes_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING[i])
            send_byte(OPENING[i][7:0], OPENING[i][8]);
        wait_drained();

        // first random stretch runs flat out, later ones mix idling
        src_pauses  = 1'b0;
        snk_pauses  = 1'b0;
        fresh       = 1'b1;
        segment_end = bytes_sent + SEGMENT;
        while (bytes_sent < ITEM_TARGET)
        begin
            send_block(fresh, broken);
            // mostly restart after a cut block; sometimes run on misaligned
            fresh = broken ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
            if (bytes_sent >= segment_end)
            begin
                wait_drained();
                src_pauses  = ($urandom_range(0, 3) != 0);
                snk_pauses  = ($urandom_range(0, 3) != 0);
                segment_end = bytes_sent + SEGMENT;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : sample_sink
        int stall;
        sample_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = snk_pauses ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                sample_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            sample_ch.ready <= 1'b1;
            @(posedge clk);
            while (!sample_ch.valid) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((stream_ch.valid && stream_ch.ready) || (sample_ch.valid && sample_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
